[hdl/pgfs_pkg.sv]
// Shared widths and limits for the process grid factor selector.
`timescale 1ns / 1ps

package pgfs_pkg;

    // Field widths of a request and of a result.
    localparam int RANK_W = 13;
    localparam int DIM_W  = 2;
    localparam int SIZE_W = 21;

    // Candidate counter: holds one past the largest rank count.
    localparam int CAND_W = RANK_W + 1;

    // Score terms: sum = a + b, num = 4*min + d*sum, den = 2*sum.
    localparam int SUM_W  = RANK_W + 1;
    localparam int NUM_W  = SUM_W + 2;
    localparam int DEN_W  = SUM_W + 1;
    localparam int PROD_W = NUM_W + DEN_W;

    // Largest candidate factor that is scored.
    localparam int MAX_RANKS = 4096;
    localparam int LIMIT_W   = 17;
    localparam logic [LIMIT_W-1:0] MAX_RANKS_LIM = LIMIT_W'(MAX_RANKS);

    // Dimension codes: DIM_PLANE selects the trivial split, DIM_SOLID uses both sizes.
    localparam logic [DIM_W-1:0] DIM_PLANE = 2'd2;
    localparam logic [DIM_W-1:0] DIM_SOLID = 2'd3;

    // One quotient bit per step over the widest dividend.
    localparam int DIV_STEPS = SIZE_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

endpackage

[hdl/process_grid_factor_select_core.sv]
// Process grid factor selector: splits a rank count into two grid factors.
`timescale 1ns / 1ps

// Channel   Signals                                         Handshake
// -------   ---------------------------------------------   ---------------------------
// request   rank_count, dim_count, size_y, size_z           taken when start && !busy
// result    first_factor, second_factor                     valid for one cycle on done
//
// A two-dimensional request is answered in the cycle after it is taken and leaves busy low.
// Any other request walks the candidates a = 1 .. min(n, 4096) on one shared restoring
// divider, one quotient bit a cycle over 21 bits, to test n mod a for each candidate,
// and a divisor then goes on to two grid tests, a score, two multiplies and a compare.
// Reset is asynchronous and returns to idle; the receiver cannot stall, so done is a
// one-cycle strobe and results hold until the next.
module process_grid_factor_select_core
    import pgfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [RANK_W-1:0] rank_count,
    input  logic [DIM_W-1:0]  dim_count,
    input  logic [SIZE_W-1:0] size_y,
    input  logic [SIZE_W-1:0] size_z,
    output logic              done,
    output logic [RANK_W-1:0] first_factor,
    output logic [RANK_W-1:0] second_factor
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_SCORE,
        ST_MUL1,
        ST_MUL2,
        ST_CMP
    } state_t;

    // Which of the three divisions the shared divider is working on.
    typedef enum logic [1:0] {
        PH_RANK,
        PH_ZDIM,
        PH_YDIM
    } phase_t;

    state_t              state_reg;
    phase_t              phase_reg;

    logic [RANK_W-1:0]   n_reg;
    logic [SIZE_W-1:0]   ny_reg;
    logic [SIZE_W-1:0]   nz_reg;
    logic [CAND_W-1:0]   a_reg;
    logic [RANK_W-1:0]   b_reg;
    logic                hit_z_reg;
    logic                hit_y_reg;

    // Restoring divider: dividend and quotient share one shift register.
    logic [SIZE_W-1:0]   dvd_reg;
    logic [RANK_W-1:0]   rem_reg;
    logic [RANK_W-1:0]   dvs_reg;
    logic [DCNT_W-1:0]   cnt_reg;

    logic [NUM_W-1:0]    num_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [NUM_W-1:0]    best_num_reg;
    logic [DEN_W-1:0]    best_den_reg;
    logic [RANK_W-1:0]   best_a_reg;
    logic [RANK_W-1:0]   best_b_reg;
    logic [PROD_W-1:0]   prod_new_reg;
    logic [PROD_W-1:0]   prod_best_reg;

    logic                done_reg;
    logic [RANK_W-1:0]   first_factor_reg;
    logic [RANK_W-1:0]   second_factor_reg;

    // Divider step.
    logic [RANK_W:0]     rem_shift;
    logic [RANK_W+1:0]   rem_diff;
    logic                q_bit;
    logic [RANK_W-1:0]   rem_step;
    logic [SIZE_W-1:0]   dvd_step;
    logic                div_last;

    // Score terms of the current candidate.
    logic [RANK_W-1:0]   cand_a;
    logic [RANK_W-1:0]   min_ab;
    logic [SUM_W-1:0]    sum_ab;
    logic [DEN_W-1:0]    hit_term;

    // Shared multiplier.
    logic [NUM_W-1:0]    mul_x;
    logic [DEN_W-1:0]    mul_y;
    logic [PROD_W-1:0]   mul_out;

    logic                scan_end;

    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[SIZE_W-1]};
        rem_diff  = {1'b0, rem_shift} - {2'b00, dvs_reg};
        q_bit     = ~rem_diff[RANK_W+1];
        rem_step  = q_bit ? rem_diff[RANK_W-1:0] : rem_shift[RANK_W-1:0];
        dvd_step  = {dvd_reg[SIZE_W-2:0], q_bit};
        div_last  = (cnt_reg == DCNT_W'(DIV_STEPS - 1));
    end

    always_comb
    begin
        cand_a = a_reg[RANK_W-1:0];
        min_ab = (cand_a < b_reg) ? cand_a : b_reg;
        sum_ab = {1'b0, cand_a} + {1'b0, b_reg};
        // Each divisibility hit adds half a point, i.e. sum over a denominator of 2*sum.
        case ({hit_z_reg, hit_y_reg})
            2'b11:   hit_term = {sum_ab, 1'b0};
            2'b10:   hit_term = {1'b0, sum_ab};
            2'b01:   hit_term = {1'b0, sum_ab};
            default: hit_term = '0;
        endcase
    end

    // Scores are compared by cross multiplication: num * best_den against best_num * den.
    always_comb
    begin
        if (state_reg == ST_MUL1)
        begin
            mul_x = num_reg;
            mul_y = best_den_reg;
        end
        else
        begin
            mul_x = best_num_reg;
            mul_y = den_reg;
        end
        mul_out = {{DEN_W{1'b0}}, mul_x} * {{NUM_W{1'b0}}, mul_y};
    end

    // The scan stops past the rank count or past the largest scored factor.
    assign scan_end = (a_reg > {1'b0, n_reg}) ||
                      ({{(LIMIT_W-CAND_W){1'b0}}, a_reg} > MAX_RANKS_LIM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            phase_reg         <= PH_RANK;
            done_reg          <= 1'b0;
            first_factor_reg  <= '0;
            second_factor_reg <= '0;
            cnt_reg           <= '0;
            a_reg             <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    done_reg <= start && (dim_count == DIM_PLANE);
                    if (start)
                    begin
                        n_reg        <= rank_count;
                        a_reg        <= CAND_W'(1);
                        best_a_reg   <= RANK_W'(1);
                        best_b_reg   <= rank_count;
                        best_num_reg <= '0;
                        best_den_reg <= DEN_W'(1);
                        // A plane grid needs no search at all.
                        if (dim_count == DIM_PLANE)
                        begin
                            first_factor_reg  <= RANK_W'(1);
                            second_factor_reg <= rank_count;
                        end
                        else
                        begin
                            // Below three dimensions the unused axes count as size one.
                            ny_reg    <= (dim_count == DIM_SOLID) ? size_y : SIZE_W'(1);
                            nz_reg    <= (dim_count == DIM_SOLID) ? size_z : SIZE_W'(1);
                            state_reg <= ST_CHECK;
                        end
                    end
                end

                ST_CHECK:
                begin
                    done_reg <= scan_end;
                    if (scan_end)
                    begin
                        first_factor_reg  <= best_a_reg;
                        second_factor_reg <= best_b_reg;
                        state_reg         <= ST_IDLE;
                    end
                    else
                    begin
                        dvd_reg   <= {{(SIZE_W-RANK_W){1'b0}}, n_reg};
                        dvs_reg   <= a_reg[RANK_W-1:0];
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        phase_reg <= PH_RANK;
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    done_reg <= 1'b0;
                    if (div_last)
                    begin
                        cnt_reg <= '0;
                        rem_reg <= '0;
                        case (phase_reg)
                            PH_RANK:
                            begin
                                if (rem_step != '0)
                                begin
                                    a_reg     <= a_reg + CAND_W'(1);
                                    state_reg <= ST_CHECK;
                                end
                                else
                                begin
                                    b_reg     <= dvd_step[RANK_W-1:0];
                                    dvd_reg   <= nz_reg;
                                    dvs_reg   <= a_reg[RANK_W-1:0];
                                    phase_reg <= PH_ZDIM;
                                end
                            end
                            PH_ZDIM:
                            begin
                                hit_z_reg <= (rem_step == '0);
                                dvd_reg   <= ny_reg;
                                dvs_reg   <= b_reg;
                                phase_reg <= PH_YDIM;
                            end
                            PH_YDIM:
                            begin
                                hit_y_reg <= (rem_step == '0);
                                state_reg <= ST_SCORE;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                    else
                    begin
                        dvd_reg <= dvd_step;
                        rem_reg <= rem_step;
                        cnt_reg <= cnt_reg + DCNT_W'(1);
                    end
                end

                ST_SCORE:
                begin
                    done_reg  <= 1'b0;
                    num_reg   <= {1'b0, min_ab, 2'b00} + {1'b0, hit_term};
                    den_reg   <= {sum_ab, 1'b0};
                    state_reg <= ST_MUL1;
                end

                ST_MUL1:
                begin
                    done_reg     <= 1'b0;
                    prod_new_reg <= mul_out;
                    state_reg    <= ST_MUL2;
                end

                ST_MUL2:
                begin
                    done_reg      <= 1'b0;
                    prod_best_reg <= mul_out;
                    state_reg     <= ST_CMP;
                end

                ST_CMP:
                begin
                    done_reg <= 1'b0;
                    // Only a strictly better score replaces the earlier pair.
                    if (prod_new_reg > prod_best_reg)
                    begin
                        best_num_reg <= num_reg;
                        best_den_reg <= den_reg;
                        best_a_reg   <= cand_a;
                        best_b_reg   <= b_reg;
                    end
                    a_reg     <= a_reg + CAND_W'(1);
                    state_reg <= ST_CHECK;
                end

                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign first_factor  = first_factor_reg;
    assign second_factor = second_factor_reg;

`ifndef ASSERT_OFF
    // A taken request is either answered at once or keeps the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("request taken but neither busy nor done");

    // The divider remainder always stays below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < dvs_reg))
        else $error("divider remainder not below divisor");

    // The chosen pair multiplies back to the rank count of the request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && busy == 1'b0 && $past(state_reg) == ST_CHECK) |->
        (({{RANK_W{1'b0}}, first_factor} * {{RANK_W{1'b0}}, second_factor}) ==
         {{RANK_W{1'b0}}, n_reg}))
        else $error("factor pair does not multiply to the rank count");

    // The candidate counter never runs more than one past the rank count.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (a_reg <= ({1'b0, n_reg} + CAND_W'(1))))
        else $error("candidate counter ran past the rank count");
`endif

endmodule
